### rtl/cie_pkg.sv
`default_nettype none

package cie_pkg;

    // Base opcodes produced by the expander
    localparam logic [6:0] OP_IMM    = 7'h13;
    localparam logic [6:0] OP_LOAD   = 7'h03;
    localparam logic [6:0] OP_STORE  = 7'h23;
    localparam logic [6:0] OP_IMM32  = 7'h1b;
    localparam logic [6:0] OP_LUI    = 7'h37;
    localparam logic [6:0] OP_REG    = 7'h33;
    localparam logic [6:0] OP_REG32  = 7'h3b;
    localparam logic [6:0] OP_JALR   = 7'h67;
    localparam logic [6:0] OP_BRANCH = 7'h63;
    localparam logic [6:0] OP_JAL    = 7'h6f;

    localparam logic [31:0] WORD_EBREAK = 32'h0010_0073;
    localparam logic [11:0] SRA_FLAG    = 12'h400;

    // Widths of one item on either side
    localparam int unsigned HALF_W = 16;
    localparam int unsigned WORD_W = 32;

    // Result of expanding one halfword
    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic              legal;
    } cie_result_t;

endpackage : cie_pkg

`default_nettype wire

### rtl/compressed_instruction_expander_core.sv
// Channel   Dir  Fields (tdata / tuser)                  Handshake
// s_axis    in   tdata[15:0] = halfword                  tvalid/tready
// m_axis    out  tdata[31:0] = expanded_word,            tvalid/tready
//                tuser[0]    = is_legal
//
// One item per cycle sustained while m_axis_tready stays high; an accepted
// halfword goes through the input register, decode and the result register to m_axis.
// rst_n clears both stage valid flags; the data registers are not reset.
// A stall on m_axis holds the result; the input stage still takes an item
// whenever it is empty or its item moves into the result register.
`default_nettype none

module compressed_instruction_expander_core (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       s_axis_tvalid,
    output logic                            s_axis_tready,
    input  wire logic [cie_pkg::HALF_W-1:0] s_axis_tdata,   // [15:0] halfword
    output logic                            m_axis_tvalid,
    input  wire logic                       m_axis_tready,
    output logic [cie_pkg::WORD_W-1:0]      m_axis_tdata,   // [31:0] expanded_word
    output logic                            m_axis_tuser    // [0] is_legal
);
    import cie_pkg::*;

    logic              in_valid_reg;
    logic              in_valid_next;
    logic [HALF_W-1:0] half_reg;
    logic              out_valid_reg;
    logic              out_valid_next;
    cie_result_t       result_reg;
    cie_result_t       decoded;
    logic              in_take;
    logic              out_load;

    // Move the input item into the result register when it has room
    assign out_load      = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || out_load;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        in_valid_next  = in_take || (in_valid_reg && !out_load);
        out_valid_next = out_load || (out_valid_reg && !m_axis_tready);
    end

    // Hold stage valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Capture the halfword and the expanded result
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            half_reg <= s_axis_tdata;
        end
        if (out_load)
        begin
            result_reg <= decoded;
        end
    end

    cie_decode u_decode (
        .half   (half_reg),
        .result (decoded)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = result_reg.word;
    assign m_axis_tuser  = result_reg.legal;

    // An illegal result carries a zero word
    a_illegal_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == 32'd0)
        else $error("illegal result with nonzero word");

    // A legal result is a full-length base instruction
    a_legal_len: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[1:0] == 2'b11)
        else $error("legal result is not a 32-bit encoding");

    // A loaded result shows on the output in the next cycle
    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> m_axis_tvalid)
        else $error("loaded result not presented");

    // Both stages full and output stalled: take no new item
    a_full_block: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && out_valid_reg && !m_axis_tready |-> !s_axis_tready)
        else $error("input accepted while pipeline full");

endmodule : compressed_instruction_expander_core

`default_nettype wire

### rtl/cie_decode.sv
`default_nettype none

module cie_decode (
    input  wire logic [cie_pkg::HALF_W-1:0] half,
    output cie_pkg::cie_result_t            result
);
    import cie_pkg::*;

    // Quadrant codes
    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;

    // Compressed funct3 codes per quadrant
    localparam logic [2:0] C0_ADDI4SPN = 3'd0;
    localparam logic [2:0] C0_LW       = 3'd2;
    localparam logic [2:0] C0_LD       = 3'd3;
    localparam logic [2:0] C0_SW       = 3'd6;
    localparam logic [2:0] C0_SD       = 3'd7;

    localparam logic [2:0] C1_ADDI     = 3'd0;
    localparam logic [2:0] C1_ADDIW    = 3'd1;
    localparam logic [2:0] C1_LI       = 3'd2;
    localparam logic [2:0] C1_LUI      = 3'd3;
    localparam logic [2:0] C1_MISC_ALU = 3'd4;
    localparam logic [2:0] C1_J        = 3'd5;
    localparam logic [2:0] C1_BEQZ     = 3'd6;
    localparam logic [2:0] C1_BNEZ     = 3'd7;

    localparam logic [2:0] C2_SLLI     = 3'd0;
    localparam logic [2:0] C2_LWSP     = 3'd2;
    localparam logic [2:0] C2_LDSP     = 3'd3;
    localparam logic [2:0] C2_JR_MV    = 3'd4;
    localparam logic [2:0] C2_SWSP     = 3'd6;
    localparam logic [2:0] C2_SDSP     = 3'd7;

    // Sub-op codes of the register/immediate ALU group
    localparam logic [1:0] SUB_SRLI = 2'd0;
    localparam logic [1:0] SUB_SRAI = 2'd1;
    localparam logic [1:0] SUB_ANDI = 2'd2;
    localparam logic [1:0] SUB_REG  = 2'd3;
    localparam logic [1:0] AR_SUB   = 2'd0;
    localparam logic [1:0] AR_XOR   = 2'd1;
    localparam logic [1:0] AR_OR    = 2'd2;

    // Base funct3 codes
    localparam logic [2:0] F3_ADD  = 3'd0;
    localparam logic [2:0] F3_SLL  = 3'd1;
    localparam logic [2:0] F3_WORD = 3'd2;
    localparam logic [2:0] F3_DBL  = 3'd3;
    localparam logic [2:0] F3_XOR  = 3'd4;
    localparam logic [2:0] F3_SR   = 3'd5;
    localparam logic [2:0] F3_OR   = 3'd6;
    localparam logic [2:0] F3_AND  = 3'd7;
    localparam logic [2:0] F3_BEQ  = 3'd0;
    localparam logic [2:0] F3_BNE  = 3'd1;

    localparam logic [6:0] F7_ALT  = 7'h20;
    localparam logic [6:0] F7_BASE = 7'h00;

    localparam logic [4:0] REG_ZERO = 5'd0;
    localparam logic [4:0] REG_RA   = 5'd1;
    localparam logic [4:0] REG_SP   = 5'd2;

    function automatic logic [31:0] mk_i(input logic [11:0] imm, input logic [4:0] rs1,
                                         input logic [2:0] f3, input logic [4:0] rd,
                                         input logic [6:0] op);
        mk_i = {imm, rs1, f3, rd, op};
    endfunction

    function automatic logic [31:0] mk_r(input logic [6:0] f7, input logic [4:0] rs2,
                                         input logic [4:0] rs1, input logic [2:0] f3,
                                         input logic [4:0] rd, input logic [6:0] op);
        mk_r = {f7, rs2, rs1, f3, rd, op};
    endfunction

    function automatic logic [31:0] mk_s(input logic [11:0] imm, input logic [4:0] rs2,
                                         input logic [4:0] rs1, input logic [2:0] f3);
        mk_s = {imm[11:5], rs2, rs1, f3, imm[4:0], OP_STORE};
    endfunction

    function automatic logic [31:0] mk_b(input logic [12:0] imm, input logic [4:0] rs1,
                                         input logic [2:0] f3);
        mk_b = {imm[12], imm[10:5], REG_ZERO, rs1, f3, imm[4:1], imm[11], OP_BRANCH};
    endfunction

    function automatic logic [31:0] mk_j(input logic [20:0] imm);
        mk_j = {imm[20], imm[10:1], imm[11], imm[19:12], REG_ZERO, OP_JAL};
    endfunction

    logic [1:0]  quad;
    logic [2:0]  f3;
    logic [4:0]  rd;
    logic [4:0]  rs2;
    logic [4:0]  rdp;
    logic [4:0]  rsp;
    logic        b12;
    logic [1:0]  sub;
    logic [1:0]  ar;
    logic [11:0] ci;
    logic        ci_zero;
    logic [9:0]  imm_4spn;
    logic [9:0]  imm_16sp;
    logic [11:0] imm_j;
    logic [8:0]  imm_b;
    logic [2:0]  ar_f3;
    logic [6:0]  ar_f7;
    logic [31:0] word;
    logic        legal;

    // Split out the common fields
    always_comb
    begin
        quad     = half[1:0];
        f3       = half[15:13];
        rd       = half[11:7];
        rs2      = half[6:2];
        rdp      = {2'b01, half[4:2]};
        rsp      = {2'b01, half[9:7]};
        b12      = half[12];
        sub      = half[11:10];
        ar       = half[6:5];
        ci       = {{6{half[12]}}, half[12], half[6:2]};
        ci_zero  = ({half[12], half[6:2]} == 6'd0);
        imm_4spn = {half[10:7], half[12:11], half[5], half[6], 2'b00};
        imm_16sp = {half[12], half[4:3], half[5], half[2], half[6], 4'b0000};
        imm_j    = {half[12], half[8], half[10:9], half[6], half[7], half[2],
                    half[11], half[5:3], 1'b0};
        imm_b    = {half[12], half[6:5], half[2], half[11:10], half[4:3], 1'b0};
        ar_f7    = (ar == AR_SUB) ? F7_ALT : F7_BASE;
        case (ar)
            AR_SUB:  ar_f3 = F3_ADD;
            AR_XOR:  ar_f3 = F3_XOR;
            AR_OR:   ar_f3 = F3_OR;
            default: ar_f3 = F3_AND;
        endcase
    end

    // Expand by quadrant and funct3
    always_comb
    begin
        word  = 32'd0;
        legal = 1'b0;
        case (quad)
            QUAD_0:
            begin
                case (f3)
                    C0_ADDI4SPN:
                    begin
                        legal = (imm_4spn != 10'd0);
                        word  = mk_i({2'b00, imm_4spn}, REG_SP, F3_ADD, rdp, OP_IMM);
                    end
                    C0_LW:
                    begin
                        legal = 1'b1;
                        word  = mk_i({5'd0, half[5], half[12:10], half[6], 2'b00},
                                     rsp, F3_WORD, rdp, OP_LOAD);
                    end
                    C0_SW:
                    begin
                        legal = 1'b1;
                        word  = mk_s({5'd0, half[5], half[12:10], half[6], 2'b00},
                                     rdp, rsp, F3_WORD);
                    end
                    C0_LD:
                    begin
                        legal = 1'b1;
                        word  = mk_i({4'd0, half[6:5], half[12:10], 3'b000},
                                     rsp, F3_DBL, rdp, OP_LOAD);
                    end
                    C0_SD:
                    begin
                        legal = 1'b1;
                        word  = mk_s({4'd0, half[6:5], half[12:10], 3'b000},
                                     rdp, rsp, F3_DBL);
                    end
                    default:
                    begin
                        legal = 1'b0;
                    end
                endcase
            end
            QUAD_1:
            begin
                case (f3)
                    C1_ADDI:
                    begin
                        legal = 1'b1;
                        word  = mk_i(ci, rd, F3_ADD, rd, OP_IMM);
                    end
                    C1_ADDIW:
                    begin
                        legal = (rd != REG_ZERO);
                        word  = mk_i(ci, rd, F3_ADD, rd, OP_IMM32);
                    end
                    C1_LI:
                    begin
                        legal = 1'b1;
                        word  = mk_i(ci, REG_ZERO, F3_ADD, rd, OP_IMM);
                    end
                    C1_LUI:
                    begin
                        // Stack adjust when rd is sp, upper immediate otherwise
                        legal = !ci_zero;
                        if (rd == REG_SP)
                        begin
                            word = mk_i({{2{half[12]}}, imm_16sp}, REG_SP, F3_ADD,
                                        REG_SP, OP_IMM);
                        end
                        else
                        begin
                            word = {{14{half[12]}}, half[12], half[6:2], rd, OP_LUI};
                        end
                    end
                    C1_MISC_ALU:
                    begin
                        case (sub)
                            SUB_ANDI:
                            begin
                                legal = 1'b1;
                                word  = mk_i(ci, rsp, F3_AND, rsp, OP_IMM);
                            end
                            SUB_SRLI, SUB_SRAI:
                            begin
                                legal = 1'b1;
                                word  = mk_i({6'd0, half[12], half[6:2]} |
                                             ((sub == SUB_SRAI) ? SRA_FLAG : 12'd0),
                                             rsp, F3_SR, rsp, OP_IMM);
                            end
                            default:
                            begin
                                if (!b12)
                                begin
                                    legal = 1'b1;
                                    word  = mk_r(ar_f7, rdp, rsp, ar_f3, rsp, OP_REG);
                                end
                                else
                                begin
                                    // Only SUBW and ADDW exist in the word group
                                    legal = (ar == AR_SUB) || (ar == AR_XOR);
                                    word  = mk_r(ar_f7, rdp, rsp, F3_ADD, rsp, OP_REG32);
                                end
                            end
                        endcase
                    end
                    C1_J:
                    begin
                        legal = 1'b1;
                        word  = mk_j({{9{half[12]}}, imm_j});
                    end
                    C1_BEQZ, C1_BNEZ:
                    begin
                        legal = 1'b1;
                        word  = mk_b({{4{half[12]}}, imm_b}, rsp,
                                     (f3 == C1_BEQZ) ? F3_BEQ : F3_BNE);
                    end
                    default:
                    begin
                        legal = 1'b0;
                    end
                endcase
            end
            QUAD_2:
            begin
                case (f3)
                    C2_SLLI:
                    begin
                        legal = 1'b1;
                        word  = mk_i({6'd0, half[12], half[6:2]}, rd, F3_SLL, rd, OP_IMM);
                    end
                    C2_LWSP:
                    begin
                        legal = (rd != REG_ZERO);
                        word  = mk_i({4'd0, half[3:2], half[12], half[6:4], 2'b00},
                                     REG_SP, F3_WORD, rd, OP_LOAD);
                    end
                    C2_LDSP:
                    begin
                        legal = (rd != REG_ZERO);
                        word  = mk_i({3'd0, half[4:2], half[12], half[6:5], 3'b000},
                                     REG_SP, F3_DBL, rd, OP_LOAD);
                    end
                    C2_JR_MV:
                    begin
                        legal = 1'b1;
                        if (!b12)
                        begin
                            if (rs2 == REG_ZERO)
                            begin
                                legal = (rd != REG_ZERO);
                                word  = mk_i(12'd0, rd, F3_ADD, REG_ZERO, OP_JALR);
                            end
                            else
                            begin
                                word = mk_r(F7_BASE, rs2, REG_ZERO, F3_ADD, rd, OP_REG);
                            end
                        end
                        else if (rs2 == REG_ZERO)
                        begin
                            word = (rd == REG_ZERO) ? WORD_EBREAK
                                 : mk_i(12'd0, rd, F3_ADD, REG_RA, OP_JALR);
                        end
                        else
                        begin
                            word = mk_r(F7_BASE, rs2, rd, F3_ADD, rd, OP_REG);
                        end
                    end
                    C2_SWSP:
                    begin
                        legal = 1'b1;
                        word  = mk_s({4'd0, half[8:7], half[12:9], 2'b00},
                                     rs2, REG_SP, F3_WORD);
                    end
                    C2_SDSP:
                    begin
                        legal = 1'b1;
                        word  = mk_s({3'd0, half[9:7], half[12:10], 3'b000},
                                     rs2, REG_SP, F3_DBL);
                    end
                    default:
                    begin
                        legal = 1'b0;
                    end
                endcase
            end
            default:
            begin
                legal = 1'b0;
            end
        endcase
    end

    // Zero the word of an illegal encoding
    assign result.legal = legal;
    assign result.word  = legal ? word : 32'd0;

endmodule : cie_decode

`default_nettype wire

### verif/testbench.sv
`timescale 1ns / 1ps

module testbench;

    import cie_pkg::*;

    // One row of the directed table; typed rows carry their expected result
    typedef struct packed {
        logic [15:0] half;
        logic        typed;
        logic [31:0] word;
        logic        legal;
    } stimulus_row_t;

    // One expansion waiting for its result item
    typedef struct {
        logic [15:0] half;
        cie_result_t res;
    } pending_expansion_t;

    localparam int RANDOM_ITEMS = 450;
    localparam int QUIET_ITEMS  = 60;
    localparam int DIRECTED_N   = 25;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;     // [15:0] halfword
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;     // [31:0] expanded_word
    logic        m_axis_tuser;     // [0] is_legal

    // Expectation that travels with the item on the slave side
    logic        row_typed;
    logic [31:0] row_word;
    logic        row_legal;

    logic        quiet_phase;
    int unsigned mismatch_count;
    pending_expansion_t pending_expansions[$];

    // Illegal encodings, extremes and a few operations at full field values
    stimulus_row_t directed_rows [DIRECTED_N] = '{
        '{16'h0000, 1'b1, 32'h0000_0000, 1'b0},   // all zero: ADDI4SPN with zero immediate
        '{16'hFFFF, 1'b1, 32'h0000_0000, 1'b0},   // quadrant three
        '{16'h0003, 1'b1, 32'h0000_0000, 1'b0},   // quadrant three, rest clear
        '{16'h2000, 1'b1, 32'h0000_0000, 1'b0},   // FLD
        '{16'hA000, 1'b1, 32'h0000_0000, 1'b0},   // FSD
        '{16'h8000, 1'b1, 32'h0000_0000, 1'b0},   // quadrant zero reserved funct3
        '{16'h2001, 1'b1, 32'h0000_0000, 1'b0},   // ADDIW to x0
        '{16'h6101, 1'b1, 32'h0000_0000, 1'b0},   // ADDI16SP with zero immediate
        '{16'h6081, 1'b1, 32'h0000_0000, 1'b0},   // LUI with zero immediate
        '{16'h9C41, 1'b1, 32'h0000_0000, 1'b0},   // reserved word-register op
        '{16'h9C61, 1'b1, 32'h0000_0000, 1'b0},   // reserved word-register op
        '{16'h4002, 1'b1, 32'h0000_0000, 1'b0},   // LWSP to x0
        '{16'h6002, 1'b1, 32'h0000_0000, 1'b0},   // LDSP to x0
        '{16'h8002, 1'b1, 32'h0000_0000, 1'b0},   // JR through x0
        '{16'h2002, 1'b1, 32'h0000_0000, 1'b0},   // FLDSP
        '{16'hA002, 1'b1, 32'h0000_0000, 1'b0},   // FSDSP
        '{16'h9002, 1'b1, 32'h0010_0073, 1'b1},   // EBREAK
        '{16'h0001, 1'b1, 32'h0000_0013, 1'b1},   // NOP as ADDI x0, x0, 0
        '{16'h1FFC, 1'b0, 32'h0000_0000, 1'b0},   // ADDI4SPN, largest immediate
        '{16'h717D, 1'b0, 32'h0000_0000, 1'b0},   // ADDI16SP, all immediate bits set
        '{16'h97FD, 1'b0, 32'h0000_0000, 1'b0},   // SRAI
        '{16'h9FBD, 1'b0, 32'h0000_0000, 1'b0},   // ADDW
        '{16'hBFFD, 1'b0, 32'h0000_0000, 1'b0},   // J, all offset bits set
        '{16'h9F82, 1'b0, 32'h0000_0000, 1'b0},   // JALR x31
        '{16'hFFFE, 1'b0, 32'h0000_0000, 1'b0}    // SDSP, largest offset
    };

    compressed_instruction_expander_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #5 clk = ~clk;

    // Base instruction formats
    function automatic logic [31:0] fmt_i(input logic [11:0] imm, input logic [4:0] rs1,
                                          input logic [2:0] f3, input logic [4:0] rd,
                                          input logic [6:0] op);
        return {imm, rs1, f3, rd, op};
    endfunction

    function automatic logic [31:0] fmt_r(input logic [6:0] f7, input logic [4:0] rs2,
                                          input logic [4:0] rs1, input logic [2:0] f3,
                                          input logic [4:0] rd, input logic [6:0] op);
        return {f7, rs2, rs1, f3, rd, op};
    endfunction

    function automatic logic [31:0] fmt_s(input logic [11:0] imm, input logic [4:0] rs2,
                                          input logic [4:0] rs1, input logic [2:0] f3);
        return {imm[11:5], rs2, rs1, f3, imm[4:0], OP_STORE};
    endfunction

    function automatic logic [31:0] fmt_b(input logic [12:0] imm, input logic [4:0] rs1,
                                          input logic [2:0] f3);
        return {imm[12], imm[10:5], 5'd0, rs1, f3, imm[4:1], imm[11], OP_BRANCH};
    endfunction

    function automatic logic [31:0] fmt_j(input logic [20:0] imm);
        return {imm[20], imm[10:1], imm[11], imm[19:12], 5'd0, OP_JAL};
    endfunction

    // Expand one compressed halfword into its base instruction and legal flag
    function automatic cie_result_t expand_halfword(input logic [15:0] h);
        cie_result_t r;
        logic [2:0]  f3;
        logic [4:0]  rd;
        logic [4:0]  rs2;
        logic [4:0]  rdp;
        logic [4:0]  rsp;
        logic        b12;
        logic [19:0] ci;
        logic [1:0]  sub;
        logic [1:0]  ar;
        logic [2:0]  alu_f3;
        logic [11:0] imm12;
        logic [31:0] w;
        logic        ok;
        f3  = h[15:13];
        rd  = h[11:7];
        rs2 = h[6:2];
        rdp = {2'b01, h[4:2]};
        rsp = {2'b01, h[9:7]};
        b12 = h[12];
        ci  = {{15{h[12]}}, h[6:2]};
        sub = h[11:10];
        ar  = h[6:5];
        ok  = 1'b1;
        w   = 32'd0;
        case (h[1:0])
            2'd0:
            begin
                case (f3)
                    3'd0:
                    begin
                        imm12 = {2'b00, h[10:7], h[12:11], h[5], h[6], 2'b00};
                        if (imm12 == 12'd0)
                            ok = 1'b0;
                        else
                            w = fmt_i(imm12, 5'd2, 3'd0, rdp, OP_IMM);
                    end
                    3'd2, 3'd6:
                    begin
                        imm12 = {5'd0, h[5], h[12:10], h[6], 2'b00};
                        w = (f3 == 3'd2) ? fmt_i(imm12, rsp, 3'd2, rdp, OP_LOAD)
                                         : fmt_s(imm12, rdp, rsp, 3'd2);
                    end
                    3'd3, 3'd7:
                    begin
                        imm12 = {4'd0, h[6:5], h[12:10], 3'b000};
                        w = (f3 == 3'd3) ? fmt_i(imm12, rsp, 3'd3, rdp, OP_LOAD)
                                         : fmt_s(imm12, rdp, rsp, 3'd3);
                    end
                    default: ok = 1'b0;
                endcase
            end
            2'd1:
            begin
                case (f3)
                    3'd0: w = fmt_i(ci[11:0], rd, 3'd0, rd, OP_IMM);
                    3'd1:
                    begin
                        if (rd == 5'd0)
                            ok = 1'b0;
                        else
                            w = fmt_i(ci[11:0], rd, 3'd0, rd, OP_IMM32);
                    end
                    3'd2: w = fmt_i(ci[11:0], 5'd0, 3'd0, rd, OP_IMM);
                    3'd3:
                    begin
                        if (rd == 5'd2)
                        begin
                            // stack adjust: offset in units of 16, sign from bit 12
                            imm12 = {{3{h[12]}}, h[4:3], h[5], h[2], h[6], 4'b0000};
                            if ({h[12], h[6:2]} == 6'd0)
                                ok = 1'b0;
                            else
                                w = fmt_i(imm12, 5'd2, 3'd0, 5'd2, OP_IMM);
                        end
                        else if (ci == 20'd0)
                            ok = 1'b0;
                        else
                            w = {ci, rd, OP_LUI};
                    end
                    3'd4:
                    begin
                        if (sub == 2'd2)
                            w = fmt_i(ci[11:0], rsp, 3'd7, rsp, OP_IMM);
                        else if (sub != 2'd3)
                        begin
                            imm12 = {6'd0, b12, rs2} | ((sub == 2'd1) ? SRA_FLAG : 12'd0);
                            w = fmt_i(imm12, rsp, 3'd5, rsp, OP_IMM);
                        end
                        else if (b12 == 1'b0)
                        begin
                            case (ar)
                                2'd0:    alu_f3 = 3'd0;
                                2'd1:    alu_f3 = 3'd4;
                                2'd2:    alu_f3 = 3'd6;
                                default: alu_f3 = 3'd7;
                            endcase
                            w = fmt_r((ar == 2'd0) ? 7'h20 : 7'h00, rdp, rsp, alu_f3, rsp,
                                      OP_REG);
                        end
                        else if (ar > 2'd1)
                            ok = 1'b0;
                        else
                            w = fmt_r((ar == 2'd0) ? 7'h20 : 7'h00, rdp, rsp, 3'd0, rsp,
                                      OP_REG32);
                    end
                    3'd5:
                    begin
                        imm12 = {h[12], h[8], h[10:9], h[6], h[7], h[2], h[11], h[5:3], 1'b0};
                        w = fmt_j({{9{imm12[11]}}, imm12});
                    end
                    default:
                    begin
                        imm12 = {{3{h[12]}}, h[12], h[6:5], h[2], h[11:10], h[4:3], 1'b0};
                        w = fmt_b({imm12[11], imm12}, rsp, (f3 == 3'd6) ? 3'd0 : 3'd1);
                    end
                endcase
            end
            2'd2:
            begin
                case (f3)
                    3'd0: w = fmt_i({6'd0, b12, rs2}, rd, 3'd1, rd, OP_IMM);
                    3'd2:
                    begin
                        imm12 = {4'd0, h[3:2], h[12], h[6:4], 2'b00};
                        if (rd == 5'd0)
                            ok = 1'b0;
                        else
                            w = fmt_i(imm12, 5'd2, 3'd2, rd, OP_LOAD);
                    end
                    3'd3:
                    begin
                        imm12 = {3'd0, h[4:2], h[12], h[6:5], 3'b000};
                        if (rd == 5'd0)
                            ok = 1'b0;
                        else
                            w = fmt_i(imm12, 5'd2, 3'd3, rd, OP_LOAD);
                    end
                    3'd4:
                    begin
                        if (b12 == 1'b0)
                        begin
                            if (rs2 != 5'd0)
                                w = fmt_r(7'h00, rs2, 5'd0, 3'd0, rd, OP_REG);
                            else if (rd == 5'd0)
                                ok = 1'b0;
                            else
                                w = fmt_i(12'd0, rd, 3'd0, 5'd0, OP_JALR);
                        end
                        else if (rs2 != 5'd0)
                            w = fmt_r(7'h00, rs2, rd, 3'd0, rd, OP_REG);
                        else if (rd == 5'd0)
                            w = WORD_EBREAK;
                        else
                            w = fmt_i(12'd0, rd, 3'd0, 5'd1, OP_JALR);
                    end
                    3'd6:
                    begin
                        imm12 = {4'd0, h[8:7], h[12:9], 2'b00};
                        w = fmt_s(imm12, rs2, 5'd2, 3'd2);
                    end
                    3'd7:
                    begin
                        imm12 = {3'd0, h[9:7], h[12:10], 3'b000};
                        w = fmt_s(imm12, rs2, 5'd2, 3'd3);
                    end
                    default: ok = 1'b0;
                endcase
            end
            default: ok = 1'b0;
        endcase
        r.word  = ok ? w : 32'd0;
        r.legal = ok;
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // Present one halfword, after an optional idle burst, and hold it until taken
    task automatic send_halfword(input logic [15:0] h, input logic typed,
                                 input logic [31:0] word, input logic legal);
        if (!quiet_phase && $urandom_range(0, 3) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= h;
        row_typed     <= typed;
        row_word      <= word;
        row_legal     <= legal;
        do
            @(posedge clk);
        while (!s_axis_tready);
        @(negedge clk);
    endtask

    // Random halfword, mostly in the compressed quadrants, often with
    // register or immediate fields forced to the values that make cases illegal
    function automatic logic [15:0] random_halfword();
        logic [15:0] h;
        h = 16'($urandom_range(0, 65535));
        if ($urandom_range(0, 7) != 0)
            h[1:0] = 2'($urandom_range(0, 2));
        case ($urandom_range(0, 9))
            0: h[11:7] = 5'd0;
            1: h[11:7] = 5'd2;
            2: {h[12], h[6:2]} = 6'd0;
            3:
            begin
                {h[12], h[6:2]} = 6'd0;
                h[11:7] = 5'd0;
            end
            default: ;
        endcase
        return h;
    endfunction

    // Capture accepted halfwords and check result items against the oldest expectation
    always @(posedge clk)
    begin
        pending_expansion_t exp_item;
        pending_expansion_t new_item;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_expansions.size() == 0)
                report_mismatch($sformatf("unexpected result word=%08h legal=%0b",
                                          m_axis_tdata, m_axis_tuser));
            else
            begin
                exp_item = pending_expansions.pop_front();
                if (m_axis_tdata !== exp_item.res.word)
                    report_mismatch($sformatf("halfword %04h: word %08h, expected %08h",
                                              exp_item.half, m_axis_tdata,
                                              exp_item.res.word));
                if (m_axis_tuser !== exp_item.res.legal)
                    report_mismatch($sformatf("halfword %04h: legal %0b, expected %0b",
                                              exp_item.half, m_axis_tuser,
                                              exp_item.res.legal));
            end
        end
        if (rst_n && s_axis_tvalid && s_axis_tready)
        begin
            new_item.half = s_axis_tdata;
            if (row_typed)
            begin
                new_item.res.word  = row_word;
                new_item.res.legal = row_legal;
            end
            else
                new_item.res = expand_halfword(s_axis_tdata);
            pending_expansions.push_back(new_item);
        end
    end

    // Drive the master-side ready in bursts of stall and flow
    initial
    begin
        int unsigned hold_cycles;
        hold_cycles   = 0;
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_cycles == 0)
            begin
                if (quiet_phase)
                begin
                    m_axis_tready <= 1'b1;
                    hold_cycles = 1;
                end
                else if ($urandom_range(0, 3) == 0)
                begin
                    m_axis_tready <= 1'b0;
                    hold_cycles = $urandom_range(1, 16);
                end
                else
                begin
                    m_axis_tready <= 1'b1;
                    hold_cycles = $urandom_range(1, 24);
                end
            end
            hold_cycles--;
        end
    end

    // Stimulus: reset, directed table, random halfwords, drain
    initial
    begin
        rst_n          = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = 16'd0;
        row_typed      = 1'b0;
        row_word       = 32'd0;
        row_legal      = 1'b0;
        quiet_phase    = 1'b0;
        mismatch_count = 0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int i = 0; i < DIRECTED_N; i++)
            send_halfword(directed_rows[i].half, directed_rows[i].typed,
                          directed_rows[i].word, directed_rows[i].legal);

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            quiet_phase = (i >= RANDOM_ITEMS - QUIET_ITEMS);
            send_halfword(random_halfword(), 1'b0, 32'd0, 1'b0);
        end
        s_axis_tvalid <= 1'b0;

        // Drain outstanding results, then watch for stray ones
        while (pending_expansions.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (mismatch_count == 0 && pending_expansions.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Stop a hung run
    initial
    begin
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
